>>> rtl/flowlet_load_balancer_macros.svh
// Assertion helpers used by the checker in flb_chk.sv.
`ifndef FLOWLET_LOAD_BALANCER_MACROS_SVH
`define FLOWLET_LOAD_BALANCER_MACROS_SVH

`define FLB_ASSERT_ON(ck, rn, name, prop, msg) \
  name: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

`define FLB_ASSERT(name, prop, msg) `FLB_ASSERT_ON(clk, rst_n, name, prop, msg)

`endif

>>> rtl/flb_pkg.sv
`default_nettype none
package flb_pkg;

  localparam int IN_DATA_W  = 184;
  localparam int OUT_DATA_W = 8;
  localparam int DIV_W      = 5;

  typedef struct packed {
    logic [47:0] key;
    logic [2:0]  port;
    logic [63:0] ts;
    logic [63:0] gap;
  } ent_t;

  localparam logic [2:0] POL_LETFLOW = 3'd0;
  localparam logic [2:0] POL_CONGA   = 3'd1;
  localparam logic [2:0] POL_DRILL   = 3'd2;
  localparam logic [2:0] POL_DECAY   = 3'd3;
  localparam logic [2:0] POL_ECMP    = 3'd4;
  localparam logic [2:0] POL_RANDOM  = 3'd5;

  localparam logic [2:0] REG_POLICY  = 3'd0;
  localparam logic [2:0] REG_HOST    = 3'd1;
  localparam logic [2:0] REG_DEFAULT = 3'd2;
  localparam logic [2:0] REG_PCOUNT  = 3'd3;
  localparam logic [2:0] REG_RTT     = 3'd4;
  localparam logic [2:0] REG_VTIME   = 3'd5;
  localparam logic [2:0] REG_DSTEP   = 3'd6;
  localparam logic [2:0] REG_FTO     = 3'd7;

  localparam logic [1:0] DIV_SRC_M   = 2'd0;
  localparam logic [1:0] DIV_SRC_N1  = 2'd1;
  localparam logic [1:0] DIV_SRC_SUM = 2'd2;

  localparam logic [1:0] B_SRC_LAST  = 2'd0;
  localparam logic [1:0] B_SRC_HOST  = 2'd1;
  localparam logic [1:0] B_SRC_REM   = 2'd2;

  localparam logic [1:0] WALK_COUNT  = 2'd0;
  localparam logic [1:0] WALK_SEL    = 2'd1;
  localparam logic [1:0] WALK_LEAST  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       qlen_wr;
    logic       idx_clr;
    logic       rd;
    logic       cmp;
    logic       hit;
    logic       inv;
    logic       miss;
    logic       decay;
    logic       regap;
    logic       fresh_set;
    logic       b_ld;
    logic [1:0] b_src;
    logic       div_start;
    logic [1:0] div_src;
    logic       walk_start;
    logic [1:0] walk_mode;
    logic       walk_step;
    logic       walk_commit;
    logic       wb;
    logic       nh;
  } cmd_t;

  typedef struct packed {
    logic       command;
    logic       host_pkt;
    logic       match;
    logic       idx_last;
    logic       stale;
    logic [2:0] policy;
    logic       idle_gt_fto;
    logic       idle_gt_gap;
    logic       n_lt2;
    logic       m_zero;
    logic       div_busy;
    logic       walk_end;
    logic       out_free;
  } sts_t;

endpackage
`default_nettype wire

>>> rtl/flb_dp.sv
`default_nettype none
module flb_dp #(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_PORTS   = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_addr,
  input  wire logic [63:0]                    cfg_wdata,
  input  wire logic                           in_tuser,
  input  wire logic [flb_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           out_tready,
  output logic                                out_tvalid,
  output logic [flb_pkg::OUT_DATA_W-1:0]      out_tdata,
  input  wire flb_pkg::cmd_t                  cmd,
  output flb_pkg::sts_t                       sts
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int JW = $clog2(MAX_PORTS + 1);
  localparam int QW = $clog2(MAX_PORTS);

  logic [2:0]  policy_r, host_r, dflt_r;
  logic [3:0]  pcnt_r;
  logic [31:0] rtt_r, dstep_r, fto_r;
  logic [63:0] vtime_r;

  logic        cmdbit_r;
  logic [2:0]  inport_r, qp_r;
  logic [47:0] key_r;
  logic [63:0] now_r;
  logic [31:0] rnd_r, qb_r;

  flb_pkg::ent_t mem [TABLE_DEPTH];
  flb_pkg::ent_t ent_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [AW-1:0] idx_r, free_r, slot_r;
  logic          free_found_r;
  logic [31:0]   qlen_r [MAX_PORTS];

  logic [2:0]  dst_r;
  logic        hit_r, fresh_r;
  logic [63:0] gap_r, idle_r;

  logic [31:0] dvd_r;
  logic [4:0]  rem_r, dsr_r, dcnt_r;
  logic        busy_r;

  logic [JW-1:0] j_r, n;
  logic [1:0]    mode_r;
  logic [4:0]    b_r, m_r, k_r, res_r;
  logic [31:0]   best_r;
  logic          seldone_r;

  logic          out_tvalid_r;
  logic [2:0]    out_dst_r;
  logic          out_hit_r, out_fresh_r;

  logic [63:0] gap9, idle_w, gap_dec;
  logic [4:0]  t_w;
  logic        elig;
  logic [31:0] q_j;
  logic [2:0]  dst_fin;
  logic [AW-1:0] miss_slot;
  flb_pkg::ent_t wb_ent;

  assign n = (5'(pcnt_r) > 5'(MAX_PORTS)) ? JW'(MAX_PORTS) : JW'(pcnt_r);
  assign gap9 = 64'({rtt_r, 3'b000}) + 64'(rtt_r);
  assign idle_w = now_r - ent_r.ts;
  assign gap_dec = (gap_r > 64'(rtt_r)) ?
                   ((gap_r > 64'(dstep_r)) ? gap_r - 64'(dstep_r) : 64'd0) : gap_r;
  assign t_w = {rem_r[3:0], dvd_r[31]};
  assign elig = (5'(j_r) != 5'(host_r)) && (5'(j_r) != b_r);
  assign q_j = qlen_r[j_r[QW-1:0]];
  assign dst_fin = (policy_r == flb_pkg::POL_ECMP) ? ({1'b0, slot_r[1:0]} + 3'd1) : dst_r;
  assign miss_slot = free_found_r ? free_r : '0;

  always_comb begin
    wb_ent.key  = key_r;
    wb_ent.port = dst_fin;
    wb_ent.ts   = now_r;
    wb_ent.gap  = gap_r;
  end

  always_comb begin
    sts.command     = cmdbit_r;
    sts.host_pkt    = (inport_r == host_r);
    sts.match       = valid_r[idx_r] && (ent_r.key == key_r);
    sts.idx_last    = (idx_r == AW'(TABLE_DEPTH - 1));
    sts.stale       = idle_w > vtime_r;
    sts.policy      = policy_r;
    sts.idle_gt_fto = idle_r > 64'(fto_r);
    sts.idle_gt_gap = idle_r > gap_r;
    sts.n_lt2       = (5'(n) < 5'd2);
    sts.m_zero      = (m_r == 5'd0);
    sts.div_busy    = busy_r;
    sts.walk_end    = (5'(j_r) >= 5'(n));
    sts.out_free    = !out_tvalid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= flb_pkg::POL_DECAY;
      host_r   <= 3'd0;
      dflt_r   <= 3'd1;
      pcnt_r   <= 4'd4;
      rtt_r    <= '0;
      vtime_r  <= '0;
      dstep_r  <= '0;
      fto_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        flb_pkg::REG_POLICY:  policy_r <= cfg_wdata[2:0];
        flb_pkg::REG_HOST:    host_r   <= cfg_wdata[2:0];
        flb_pkg::REG_DEFAULT: dflt_r   <= cfg_wdata[2:0];
        flb_pkg::REG_PCOUNT:  pcnt_r   <= cfg_wdata[3:0];
        flb_pkg::REG_RTT:     rtt_r    <= cfg_wdata[31:0];
        flb_pkg::REG_VTIME:   vtime_r  <= cfg_wdata;
        flb_pkg::REG_DSTEP:   dstep_r  <= cfg_wdata[31:0];
        flb_pkg::REG_FTO:     fto_r    <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmdbit_r <= in_tuser;
      inport_r <= in_tdata[2:0];
      key_r    <= {in_tdata[34:3], in_tdata[50:35]};
      now_r    <= in_tdata[114:51];
      rnd_r    <= in_tdata[146:115];
      qp_r     <= in_tdata[149:147];
      qb_r     <= in_tdata[181:150];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < MAX_PORTS; p++) qlen_r[p] <= '0;
    end else if (cmd.qlen_wr) begin
      for (int p = 0; p < MAX_PORTS; p++) begin
        if (5'(qp_r) == 5'(p)) qlen_r[p] <= qb_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) ent_r <= mem[idx_r];
    if (cmd.wb) mem[slot_r] <= wb_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.inv) begin
      valid_r[idx_r] <= 1'b0;
    end else if (cmd.miss && !free_found_r) begin
      valid_r <= '0;
    end else if (cmd.wb) begin
      valid_r[slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx_r        <= '0;
      free_found_r <= 1'b0;
    end else if (cmd.cmp) begin
      if (!valid_r[idx_r] && !free_found_r) begin
        free_r       <= idx_r;
        free_found_r <= 1'b1;
      end
      if (!sts.match && !sts.idx_last) idx_r <= idx_r + AW'(1);
    end else if (cmd.inv && !free_found_r) begin
      free_r       <= idx_r;
      free_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_r   <= 1'b0;
      fresh_r <= 1'b0;
    end
    if (cmd.hit) begin
      hit_r  <= 1'b1;
      dst_r  <= ent_r.port;
      gap_r  <= ent_r.gap;
      idle_r <= idle_w;
      slot_r <= idx_r;
    end
    if (cmd.miss) begin
      dst_r  <= dflt_r;
      gap_r  <= gap9;
      slot_r <= miss_slot;
    end
    if (cmd.decay) gap_r <= gap_dec;
    if (cmd.regap) gap_r <= gap9;
    if (cmd.fresh_set) fresh_r <= 1'b1;
    if (cmd.walk_commit) dst_r <= res_r[2:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      busy_r <= 1'b1;
      rem_r  <= '0;
      dcnt_r <= '0;
      case (cmd.div_src)
        flb_pkg::DIV_SRC_M: begin
          dvd_r <= rnd_r;
          dsr_r <= m_r;
        end
        flb_pkg::DIV_SRC_N1: begin
          dvd_r <= rnd_r;
          dsr_r <= 5'(n) - 5'd1;
        end
        default: begin
          dvd_r <= 32'(host_r) + 32'(rem_r) + 32'd1;
          dsr_r <= 5'(n);
        end
      endcase
    end else if (busy_r) begin
      dvd_r  <= {dvd_r[30:0], 1'b0};
      rem_r  <= (t_w >= dsr_r) ? t_w - dsr_r : t_w;
      dcnt_r <= dcnt_r + 5'd1;
      if (dcnt_r == 5'd31) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.b_ld) begin
      case (cmd.b_src)
        flb_pkg::B_SRC_LAST: b_r <= 5'(dst_r);
        flb_pkg::B_SRC_HOST: b_r <= 5'(host_r);
        default:             b_r <= rem_r;
      endcase
    end
    if (cmd.walk_start) begin
      j_r       <= '0;
      mode_r    <= cmd.walk_mode;
      res_r     <= 5'(dst_r);
      best_r    <= '1;
      k_r       <= rem_r;
      seldone_r <= 1'b0;
      if (cmd.walk_mode == flb_pkg::WALK_COUNT) m_r <= '0;
    end else if (cmd.walk_step) begin
      j_r <= j_r + JW'(1);
      if (elig) begin
        case (mode_r)
          flb_pkg::WALK_COUNT: m_r <= m_r + 5'd1;
          flb_pkg::WALK_SEL: begin
            if (!seldone_r) begin
              if (k_r == 5'd0) begin
                res_r     <= 5'(j_r);
                seldone_r <= 1'b1;
              end else begin
                k_r <= k_r - 5'd1;
              end
            end
          end
          default: begin
            if (q_j < best_r) begin
              best_r <= q_j;
              res_r  <= 5'(j_r);
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.wb || cmd.nh) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wb) begin
      out_dst_r   <= dst_fin;
      out_hit_r   <= hit_r;
      out_fresh_r <= fresh_r;
    end else if (cmd.nh) begin
      out_dst_r   <= host_r;
      out_hit_r   <= 1'b0;
      out_fresh_r <= 1'b0;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {3'b000, out_fresh_r, out_hit_r, out_dst_r};

endmodule
`default_nettype wire

>>> rtl/flb_ctrl.sv
`default_nettype none
module flb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire flb_pkg::sts_t sts,
  output flb_pkg::cmd_t      cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_DISP = 5'd1;
  localparam logic [4:0] S_RD   = 5'd2;
  localparam logic [4:0] S_CMP  = 5'd3;
  localparam logic [4:0] S_AGE  = 5'd4;
  localparam logic [4:0] S_MISS = 5'd5;
  localparam logic [4:0] S_POL  = 5'd6;
  localparam logic [4:0] S_DEC  = 5'd7;
  localparam logic [4:0] S_DEC2 = 5'd8;
  localparam logic [4:0] S_DRL  = 5'd9;
  localparam logic [4:0] S_DV1  = 5'd10;
  localparam logic [4:0] S_DV2  = 5'd11;
  localparam logic [4:0] S_CNT  = 5'd12;
  localparam logic [4:0] S_DVU  = 5'd13;
  localparam logic [4:0] S_SEL  = 5'd14;
  localparam logic [4:0] S_LST  = 5'd15;
  localparam logic [4:0] S_WB   = 5'd16;
  localparam logic [4:0] S_NH   = 5'd17;

  logic [4:0] state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.command) begin
          cmd.qlen_wr = 1'b1;
          state_nxt   = S_IDLE;
        end else if (!sts.host_pkt) begin
          state_nxt = S_NH;
        end else begin
          cmd.idx_clr = 1'b1;
          state_nxt   = S_RD;
        end
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        cmd.cmp = 1'b1;
        if (sts.match) state_nxt = S_AGE;
        else if (sts.idx_last) state_nxt = S_MISS;
        else state_nxt = S_RD;
      end
      S_AGE: begin
        if (sts.stale) begin
          cmd.inv   = 1'b1;
          state_nxt = S_MISS;
        end else begin
          cmd.hit   = 1'b1;
          state_nxt = S_POL;
        end
      end
      S_MISS: begin
        cmd.miss  = 1'b1;
        state_nxt = S_WB;
      end
      S_POL: begin
        state_nxt = S_WB;
        case (sts.policy)
          flb_pkg::POL_LETFLOW: begin
            if (sts.idle_gt_fto) begin
              cmd.fresh_set  = 1'b1;
              cmd.b_ld       = 1'b1;
              cmd.b_src      = flb_pkg::B_SRC_LAST;
              cmd.walk_start = 1'b1;
              cmd.walk_mode  = flb_pkg::WALK_COUNT;
              state_nxt      = S_CNT;
            end
          end
          flb_pkg::POL_CONGA: begin
            if (sts.idle_gt_fto) begin
              cmd.fresh_set  = 1'b1;
              cmd.b_ld       = 1'b1;
              cmd.b_src      = flb_pkg::B_SRC_LAST;
              cmd.walk_start = 1'b1;
              cmd.walk_mode  = flb_pkg::WALK_LEAST;
              state_nxt      = S_LST;
            end
          end
          flb_pkg::POL_DRILL: begin
            cmd.fresh_set = 1'b1;
            state_nxt     = S_DRL;
          end
          flb_pkg::POL_DECAY: state_nxt = S_DEC;
          flb_pkg::POL_RANDOM: begin
            cmd.fresh_set  = 1'b1;
            cmd.b_ld       = 1'b1;
            cmd.b_src      = flb_pkg::B_SRC_LAST;
            cmd.walk_start = 1'b1;
            cmd.walk_mode  = flb_pkg::WALK_COUNT;
            state_nxt      = S_CNT;
          end
          default: state_nxt = S_WB;
        endcase
      end
      S_DEC: begin
        cmd.decay = 1'b1;
        state_nxt = S_DEC2;
      end
      S_DEC2: begin
        if (sts.idle_gt_gap) begin
          cmd.regap     = 1'b1;
          cmd.fresh_set = 1'b1;
          state_nxt     = S_DRL;
        end else begin
          state_nxt = S_WB;
        end
      end
      S_DRL: begin
        if (sts.n_lt2) begin
          cmd.b_ld       = 1'b1;
          cmd.b_src      = flb_pkg::B_SRC_HOST;
          cmd.walk_start = 1'b1;
          cmd.walk_mode  = flb_pkg::WALK_LEAST;
          state_nxt      = S_LST;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = flb_pkg::DIV_SRC_N1;
          state_nxt     = S_DV1;
        end
      end
      S_DV1: begin
        if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_src   = flb_pkg::DIV_SRC_SUM;
          state_nxt     = S_DV2;
        end
      end
      S_DV2: begin
        if (!sts.div_busy) begin
          cmd.b_ld       = 1'b1;
          cmd.b_src      = flb_pkg::B_SRC_REM;
          cmd.walk_start = 1'b1;
          cmd.walk_mode  = flb_pkg::WALK_LEAST;
          state_nxt      = S_LST;
        end
      end
      S_CNT: begin
        if (!sts.walk_end) begin
          cmd.walk_step = 1'b1;
        end else if (sts.m_zero) begin
          state_nxt = S_WB;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = flb_pkg::DIV_SRC_M;
          state_nxt     = S_DVU;
        end
      end
      S_DVU: begin
        if (!sts.div_busy) begin
          cmd.walk_start = 1'b1;
          cmd.walk_mode  = flb_pkg::WALK_SEL;
          state_nxt      = S_SEL;
        end
      end
      S_SEL, S_LST: begin
        if (!sts.walk_end) begin
          cmd.walk_step = 1'b1;
        end else begin
          cmd.walk_commit = 1'b1;
          state_nxt       = S_WB;
        end
      end
      S_WB: begin
        if (sts.out_free) begin
          cmd.wb    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_NH: begin
        if (sts.out_free) begin
          cmd.nh    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/flowlet_load_balancer.sv
// Queue command: queue length written in the cycle after acceptance; non-host packet: S_DISP, then
//   S_NH sets out_tvalid once the output is free. Host packet: a read and a compare per table entry
//   scanned (up to TABLE_DEPTH), plus policy work on one shared 32-step modulo divider (up to twice).
// Throughput: one request at a time; in_tready is high only when the controller is idle.
// Reset (rst_n low, synchronous): flow table emptied, queue lengths and registers
//   return to defaults, output channel empty.
`default_nettype none
module flowlet_load_balancer #(
  parameter int TABLE_DEPTH = 64,
  parameter int MAX_PORTS   = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [2:0]                     cfg_addr,
  input  wire logic [63:0]                    cfg_wdata,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // in_port[2:0] src_ip[34:3] src_l4_port[50:35] now_ticks[114:51]
  // random_value[146:115] qlen_port[149:147] qlen_bytes[181:150]
  input  wire logic [flb_pkg::IN_DATA_W-1:0]  in_tdata,
  // command
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // egress_port[2:0] table_hit[3] new_flowlet[4]
  output logic [flb_pkg::OUT_DATA_W-1:0]      out_tdata
);

  flb_pkg::cmd_t cmd;
  flb_pkg::sts_t sts;

  flb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  flb_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_PORTS   (MAX_PORTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
`default_nettype wire

>>> rtl/flb_chk.sv
`default_nettype none
`include "flowlet_load_balancer_macros.svh"
module flb_chk (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic                           in_tuser,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [flb_pkg::OUT_DATA_W-1:0] out_tdata
);

  `FLB_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `FLB_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed")
  `FLB_ASSERT(a_busy_after_req, in_tvalid && in_tready |=> !in_tready, "ready while busy")
  `FLB_ASSERT(a_qlen_silent, in_tvalid && in_tready && in_tuser |=> !$rose(out_tvalid), "qlen result")
  `FLB_ASSERT(a_fresh_needs_hit, out_tvalid && !out_tdata[3] |-> !out_tdata[4], "flowlet on miss")

endmodule

bind flowlet_load_balancer flb_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

>>> dv/flb_checker.sv
`timescale 1ns / 1ps
module flb_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [183:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [7:0]  out_tdata,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [2:0] dst;
    logic       hit;
    logic       fresh;
  } route_t;

  route_t route_q[$];

  logic [2:0]  pol, hostp, dflt;
  logic [3:0]  pcnt;
  logic [31:0] rtt, dstep, fto;
  logic [63:0] vtime;
  bit          ent_ok[64];
  logic [47:0] ent_key[64];
  logic [2:0]  ent_port[64];
  logic [63:0] ent_ts[64];
  logic [63:0] ent_gap[64];
  logic [31:0] qlen[8];

  function automatic logic [2:0] pick_uniform(int n, int a, int b, logic [31:0] rnd,
                                               logic [2:0] keep);
    int m;
    int k;
    m = 0;
    for (int j = 0; j < n; j++) if (j != a && j != b) m++;
    if (m == 0) return keep;
    k = int'(rnd % 32'(m));
    for (int j = 0; j < n; j++) begin
      if (j == a || j == b) continue;
      if (k == 0) return j[2:0];
      k--;
    end
    return keep;
  endfunction

  function automatic logic [2:0] pick_least(int n, int a, int b, logic [2:0] keep);
    logic [31:0] best;
    logic [2:0]  res;
    best = '1;
    res = keep;
    for (int j = 0; j < n; j++) begin
      if (j == a || j == b) continue;
      if (qlen[j] < best) begin
        best = qlen[j];
        res = j[2:0];
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] pick_drill(int n, logic [31:0] rnd, logic [2:0] keep);
    int ban;
    ban = hostp;
    if (n >= 2) ban = (int'(hostp) + int'(rnd % 32'(n - 1)) + 1) % n;
    return pick_least(n, hostp, ban, keep);
  endfunction

  task automatic predict_route(input logic cmd, input logic [183:0] d);
    logic [2:0]  inp, last, dst;
    logic [47:0] key;
    logic [63:0] now, gap, idle;
    logic [31:0] rnd;
    logic        hit, fresh;
    int          n, slot;
    route_t      r;
    inp = d[2:0];
    key = {d[34:3], d[50:35]};
    now = d[114:51];
    rnd = d[146:115];
    n = (pcnt > 8) ? 8 : int'(pcnt);
    hit = 0;
    fresh = 0;
    slot = -1;
    if (cmd) begin
      qlen[d[149:147]] = d[181:150];
      return;
    end
    if (inp != hostp) begin
      r = '{hostp, 1'b0, 1'b0};
      route_q.push_back(r);
      return;
    end
    for (int i = 0; i < 64; i++)
      if (slot < 0 && ent_ok[i] && ent_key[i] == key) slot = i;
    if (slot >= 0 && (now - ent_ts[slot]) > vtime) begin
      ent_ok[slot] = 0;
      slot = -1;
    end
    dst = dflt;
    gap = 64'(rtt) * 64'd9;
    if (slot >= 0) begin
      hit = 1;
      last = ent_port[slot];
      gap = ent_gap[slot];
      idle = now - ent_ts[slot];
      dst = last;
      case (pol)
        flb_pkg::POL_LETFLOW: if (idle > 64'(fto)) begin
          dst = pick_uniform(n, hostp, last, rnd, last);
          fresh = 1;
        end
        flb_pkg::POL_CONGA: if (idle > 64'(fto)) begin
          dst = pick_least(n, hostp, last, last);
          fresh = 1;
        end
        flb_pkg::POL_DRILL: begin
          dst = pick_drill(n, rnd, last);
          fresh = 1;
        end
        flb_pkg::POL_DECAY: begin
          if (gap > 64'(rtt)) gap = (gap > 64'(dstep)) ? gap - 64'(dstep) : 64'd0;
          if (idle > gap) begin
            gap = 64'(rtt) * 64'd9;
            dst = pick_drill(n, rnd, last);
            fresh = 1;
          end
        end
        flb_pkg::POL_RANDOM: begin
          dst = pick_uniform(n, hostp, last, rnd, last);
          fresh = 1;
        end
        default: ;
      endcase
    end else begin
      for (int i = 0; i < 64; i++) if (slot < 0 && !ent_ok[i]) slot = i;
      if (slot < 0) begin
        for (int i = 0; i < 64; i++) ent_ok[i] = 0;
        slot = 0;
      end
      ent_ok[slot] = 1;
      ent_key[slot] = key;
    end
    if (pol == flb_pkg::POL_ECMP) dst = 3'(slot % 4 + 1);
    ent_port[slot] = dst;
    ent_ts[slot] = now;
    ent_gap[slot] = gap;
    r = '{dst, hit, fresh};
    route_q.push_back(r);
  endtask

  always @(posedge clk) begin
    route_t exp_r;
    if (!rst_n) begin
      pol <= flb_pkg::POL_DECAY; hostp <= 0; dflt <= 1; pcnt <= 4;
      rtt <= 0; vtime <= 0; dstep <= 0; fto <= 0;
      for (int i = 0; i < 64; i++) ent_ok[i] = 0;
      for (int i = 0; i < 8; i++) qlen[i] = 0;
      route_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          flb_pkg::REG_POLICY:  pol <= cfg_wdata[2:0];
          flb_pkg::REG_HOST:    hostp <= cfg_wdata[2:0];
          flb_pkg::REG_DEFAULT: dflt <= cfg_wdata[2:0];
          flb_pkg::REG_PCOUNT:  pcnt <= cfg_wdata[3:0];
          flb_pkg::REG_RTT:     rtt <= cfg_wdata[31:0];
          flb_pkg::REG_VTIME:   vtime <= cfg_wdata;
          flb_pkg::REG_DSTEP:   dstep <= cfg_wdata[31:0];
          flb_pkg::REG_FTO:     fto <= cfg_wdata[31:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_route(in_tuser, in_tdata);
      if (out_tvalid && out_tready) begin
        if (route_q.size() == 0) begin
          $error("unexpected route request: %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = route_q.pop_front();
          if (out_tdata[2:0] !== exp_r.dst) begin
            $error("egress_port expected %0d actual %0d", exp_r.dst, out_tdata[2:0]);
            fail_count <= fail_count + 1;
          end
          if (out_tdata[3] !== exp_r.hit) begin
            $error("table_hit expected %0d actual %0d", exp_r.hit, out_tdata[3]);
            fail_count <= fail_count + 1;
          end
          if (out_tdata[4] !== exp_r.fresh) begin
            $error("new_flowlet expected %0d actual %0d", exp_r.fresh, out_tdata[4]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= route_q.size();
  end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

  localparam int DRAIN = 300;
  localparam int LIMIT = 6000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_we = 0;
  logic [2:0]   cfg_addr = 0;
  logic [63:0]  cfg_wdata = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [183:0] in_tdata = 0;
  logic         in_tuser = 0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [7:0]   out_tdata;
  int           fail_count, pending;

  bit           quiet = 0;
  bit           hold_arm = 0;
  int           hold_left = 0;
  int           stall_left = 0;
  int           idle_cycles = 0;

  logic [2:0]   host_sel;
  logic [63:0]  now_ctr;
  logic [31:0]  flow_ip[16];
  logic [15:0]  flow_l4[16];

  flowlet_load_balancer uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  flb_checker route_chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (hold_arm) begin
      hold_arm = 0;
      hold_left <= 400;
      out_tready <= 0;
    end else if (hold_left > 0) begin
      out_tready <= 0;
      hold_left <= hold_left - 1;
    end else if (quiet) out_tready <= 1;
    else if (stall_left > 0) begin
      out_tready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(4) == 0) begin
      out_tready <= 0;
      stall_left <= $urandom_range(0, 12);
    end else out_tready <= 1;
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= LIMIT) begin
      $display("flowlet_load_balancer: mismatch");
      $finish;
    end
  end

  task automatic send_req(input logic cmd, input logic [2:0] inp, input logic [31:0] ip,
                          input logic [15:0] l4, input logic [63:0] now,
                          input logic [31:0] rnd, input logic [2:0] qp,
                          input logic [31:0] qb);
    if (!quiet && $urandom_range(3) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, qb, qp, rnd, now, l4, ip, inp};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_out();
    in_tvalid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic qlen_req(input logic [2:0] qp, input logic [31:0] qb);
    send_req(1'b1, 3'($urandom), $urandom, 16'($urandom), {$urandom, $urandom},
             $urandom, qp, qb);
  endtask

  task automatic pkt_req(input logic [2:0] inp, input int flow, input logic [63:0] step);
    now_ctr = now_ctr + step;
    send_req(1'b0, inp, flow_ip[flow], flow_l4[flow], now_ctr, $urandom, 3'($urandom),
             $urandom);
  endtask

  function automatic logic [63:0] rand_step();
    case ($urandom_range(5))
      0: return 64'($urandom_range(0, 3000));
      1: return 64'd0;
      default: return 64'($urandom_range(1, 60));
    endcase
  endfunction

  initial begin
    logic [63:0] val;
    logic [2:0]  inp;
    int          pc;
    for (int i = 0; i < 16; i++) begin
      flow_ip[i] = $urandom;
      flow_l4[i] = 16'($urandom);
    end
    flow_ip[0] = '0; flow_l4[0] = '0;
    flow_ip[1] = '1; flow_l4[1] = '1;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: defaults, queue extremes, non-host, miss then hit
    host_sel = 0;
    now_ctr = '0;
    for (int p = 0; p < 8; p++) qlen_req(3'(p), (p % 2) ? 32'hFFFF_FFFF : 32'(p));
    qlen_req(3'd7, 32'd0);
    pkt_req(3'd5, 0, 0);
    pkt_req(3'd7, 1, 0);
    pkt_req(3'd0, 0, 0);
    pkt_req(3'd0, 0, 0);
    pkt_req(3'd0, 1, 0);
    pkt_req(3'd0, 1, 5);
    pkt_req(3'd0, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    drain_out();
    write_reg(flb_pkg::REG_VTIME, '1);
    write_reg(flb_pkg::REG_RTT, 32'hFFFF_FFFF);
    write_reg(flb_pkg::REG_DSTEP, 32'hFFFF_FFFF);
    write_reg(flb_pkg::REG_FTO, 32'hFFFF_FFFF);
    write_reg(flb_pkg::REG_PCOUNT, 4'd15);
    write_reg(flb_pkg::REG_DEFAULT, 3'd7);
    for (int pl = 0; pl < 8; pl++) begin
      drain_out();
      write_reg(flb_pkg::REG_POLICY, 3'(pl));
      pkt_req(3'd0, 2, 3);
      pkt_req(3'd0, 2, '1);
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain_out();
      host_sel = 3'($urandom);
      write_reg(flb_pkg::REG_POLICY, 3'(ph % 8));
      write_reg(flb_pkg::REG_HOST, host_sel);
      write_reg(flb_pkg::REG_DEFAULT, 3'($urandom));
      pc = (ph == 0) ? 3 : (ph == 1) ? 8 : (ph == 2) ? 2 : $urandom_range(3, 8);
      if (ph == 9) pc = 15;
      write_reg(flb_pkg::REG_PCOUNT, 4'(pc));
      write_reg(flb_pkg::REG_RTT,
                (ph == 3) ? 32'hFFFF_FFFF : (ph == 0) ? 32'd0 : $urandom_range(0, 25));
      val = (ph == 0) ? 64'd0 : (ph == 1 || ph == 10) ? '1 : 64'($urandom_range(40, 4000));
      write_reg(flb_pkg::REG_VTIME, val);
      write_reg(flb_pkg::REG_DSTEP, (ph == 4) ? 32'hFFFF_FFFF : $urandom_range(0, 12));
      write_reg(flb_pkg::REG_FTO, (ph == 5) ? 32'hFFFF_FFFF : $urandom_range(0, 120));
      now_ctr = {$urandom, $urandom};
      if (ph == 11) quiet = 1;
      if (ph == 6) hold_arm = 1;
      for (int it = 0; it < 80; it++) begin
        case ($urandom_range(9))
          0, 1: qlen_req(3'($urandom), ($urandom_range(5) == 0) ? 32'hFFFF_FFFF :
                         32'($urandom_range(0, 5000)));
          2: begin
            inp = 3'($urandom);
            pkt_req(inp, $urandom_range(0, 15), rand_step());
          end
          default: begin
            if (ph == 10) begin
              now_ctr = now_ctr + 1;
              send_req(1'b0, host_sel, $urandom, 16'($urandom), now_ctr, $urandom,
                       3'($urandom), $urandom);
            end else pkt_req(host_sel, $urandom_range(0, 11), rand_step());
          end
        endcase
      end
    end

    drain_out();
    if (fail_count == 0) $display("flowlet_load_balancer: match");
    else $display("flowlet_load_balancer: mismatch");
    $finish;
  end
endmodule
